[rtl/dspr_pkg.sv]
// ----------------------------------------------------------------------------
// Dual stepper ramp generator package
// Shared constants, codes and types for the step-pulse generator and its
// channel interfaces.
// ----------------------------------------------------------------------------
package dspr_pkg;

  // Motors that are built, and the motor slots the result word carries.
  localparam int NUM_MOTORS    = 2;
  localparam int MOTOR_SLOTS   = 2;
  // Width of the saturating tick counters.
  localparam int ELAPSED_WIDTH = 32;

  localparam int DELAY_W = 16;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_SET_STEPS = 2'd1,
    CMD_SET_RAMP  = 2'd2,
    CMD_SET_DIR   = 2'd3
  } cmd_t;

  // Motor modes; code 3 behaves as disabled.
  localparam logic [1:0] MODE_STEP     = 2'd0;
  localparam logic [1:0] MODE_CONSTANT = 2'd1;
  localparam logic [1:0] MODE_DISABLED = 2'd2;

  // Ramp states.
  localparam logic [1:0] RAMP_STOP  = 2'd0;
  localparam logic [1:0] RAMP_ACCEL = 2'd1;
  localparam logic [1:0] RAMP_DECEL = 2'd2;

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_M0_MODE     = 3'd0;
  localparam logic [2:0] REG_M1_MODE     = 3'd1;
  localparam logic [2:0] REG_M0_STEP_DLY = 3'd2;
  localparam logic [2:0] REG_M1_STEP_DLY = 3'd3;
  localparam logic [2:0] REG_M0_START    = 3'd4;
  localparam logic [2:0] REG_M1_START    = 3'd5;
  localparam logic [2:0] REG_M0_INTERVAL = 3'd6;
  localparam logic [2:0] REG_M1_INTERVAL = 3'd7;

  // Per-motor running state.
  typedef struct packed {
    logic                     step_level;
    logic                     dir_level;
    logic [DELAY_W-1:0]       remaining_steps;
    logic [1:0]               ramp_mode;
    logic [DELAY_W-1:0]       ramp_delay;
    logic [ELAPSED_WIDTH-1:0] pulse_elapsed;
    logic [ELAPSED_WIDTH-1:0] ramp_elapsed;
  } motor_state_t;

  // Per-motor configuration.
  typedef struct packed {
    logic [1:0]         mode;
    logic [DELAY_W-1:0] step_delay;
    logic [DELAY_W-1:0] start_delay;
    logic [DELAY_W-1:0] ramp_interval;
  } motor_cfg_t;

endpackage

[rtl/dspr_cmd_if.sv]
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command word to the generator.
// ----------------------------------------------------------------------------
interface dspr_cmd_if;
  import dspr_pkg::*;

  logic         valid;
  logic         ready;
  cmd_t         command;
  logic         motor;
  logic [15:0]  value;

  modport source (output valid, output command, output motor, output value, input ready);
  modport sink   (input valid, input command, input motor, input value, output ready);
endinterface

[rtl/dspr_res_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one status word from the generator.
// ----------------------------------------------------------------------------
interface dspr_res_if;
  logic         valid;
  logic         ready;
  logic         step_out_0;
  logic         step_out_1;
  logic         dir_out_0;
  logic         dir_out_1;
  logic [15:0]  steps_left_0;
  logic [15:0]  steps_left_1;
  logic [15:0]  cur_delay_0;
  logic [15:0]  cur_delay_1;
  logic [1:0]   ramp_state_0;
  logic [1:0]   ramp_state_1;

  modport source (
    output valid, input ready,
    output step_out_0, output step_out_1, output dir_out_0, output dir_out_1,
    output steps_left_0, output steps_left_1, output cur_delay_0, output cur_delay_1,
    output ramp_state_0, output ramp_state_1
  );
  modport sink (
    input valid, output ready,
    input step_out_0, input step_out_1, input dir_out_0, input dir_out_1,
    input steps_left_0, input steps_left_1, input cur_delay_0, input cur_delay_1,
    input ramp_state_0, input ramp_state_1
  );
endinterface

[rtl/dual_stepper_pulse_ramp_generator_core.sv]
// ----------------------------------------------------------------------------
// Dual stepper step-pulse and ramp generator
// Two motor channels driven by tick and set-up commands, one status word out
// for every command word in.
// ----------------------------------------------------------------------------
// Each command word is captured in an input register and applied to both
// motors as it leaves that register, by a single pass of compare and
// increment logic; the updated motor state is the result word, held until
// the consumer takes it. One word is accepted every clock cycle as long as
// results are taken. A stalled result holds the input register, so at most
// one further word is taken behind it.
// Registers live at byte address 4*i over the APB port and should be written
// only while no words are in flight.
module dual_stepper_pulse_ramp_generator_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dspr_pkg::ADDR_W-1:0] paddr,
  input  logic [dspr_pkg::DATA_W-1:0] pwdata,
  output logic [dspr_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  dspr_cmd_if.sink                  item,
  dspr_res_if.source                result
);
  import dspr_pkg::*;

  localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX = '1;

  // Configuration registers.
  motor_cfg_t cfg [MOTOR_SLOTS];

  // Input register.
  logic               stage_valid;
  cmd_t               stage_command;
  logic               stage_motor;
  logic [DELAY_W-1:0] stage_value;

  // Motor state, which is also the result word.
  motor_state_t st      [MOTOR_SLOTS];
  motor_state_t st_next [MOTOR_SLOTS];
  logic         res_valid;

  logic         cfg_write;
  logic [2:0]   cfg_index;
  logic         advance;

  // APB register access.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < MOTOR_SLOTS; m++) begin
        cfg[m] <= '{mode: MODE_DISABLED, step_delay: '0, start_delay: '0,
                    ramp_interval: '0};
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_M0_MODE:     cfg[0].mode          <= pwdata[1:0];
        REG_M1_MODE:     cfg[1].mode          <= pwdata[1:0];
        REG_M0_STEP_DLY: cfg[0].step_delay    <= pwdata[DELAY_W-1:0];
        REG_M1_STEP_DLY: cfg[1].step_delay    <= pwdata[DELAY_W-1:0];
        REG_M0_START:    cfg[0].start_delay   <= pwdata[DELAY_W-1:0];
        REG_M1_START:    cfg[1].start_delay   <= pwdata[DELAY_W-1:0];
        REG_M0_INTERVAL: cfg[0].ramp_interval <= pwdata[DELAY_W-1:0];
        REG_M1_INTERVAL: cfg[1].ramp_interval <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (cfg_index)
      REG_M0_MODE:     prdata = {30'd0, cfg[0].mode};
      REG_M1_MODE:     prdata = {30'd0, cfg[1].mode};
      REG_M0_STEP_DLY: prdata = {16'd0, cfg[0].step_delay};
      REG_M1_STEP_DLY: prdata = {16'd0, cfg[1].step_delay};
      REG_M0_START:    prdata = {16'd0, cfg[0].start_delay};
      REG_M1_START:    prdata = {16'd0, cfg[1].start_delay};
      REG_M0_INTERVAL: prdata = {16'd0, cfg[0].ramp_interval};
      REG_M1_INTERVAL: prdata = {16'd0, cfg[1].ramp_interval};
      default:         prdata = '0;
    endcase
  end

  // Handshake: the input register moves on when the result slot is free.
  assign advance    = stage_valid && (!res_valid || result.ready);
  assign item.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (item.ready) begin
        stage_valid <= item.valid;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage_command <= item.command;
      stage_motor   <= item.motor;
      stage_value   <= item.value;
    end
  end

  // Per-motor update logic.
  for (genvar g = 0; g < MOTOR_SLOTS; g++) begin : g_motor
    localparam bit ACTIVE = (g < NUM_MOTORS);

    logic [ELAPSED_WIDTH-1:0] pe;
    logic [ELAPSED_WIDTH-1:0] re;
    logic                     enabled;
    logic                     addressed;
    logic                     ramping;

    assign pe        = (st[g].pulse_elapsed == ELAPSED_MAX) ? ELAPSED_MAX
                     : st[g].pulse_elapsed + 1'b1;
    assign re        = (st[g].ramp_elapsed == ELAPSED_MAX) ? ELAPSED_MAX
                     : st[g].ramp_elapsed + 1'b1;
    assign enabled   = (cfg[g].mode == MODE_STEP) || (cfg[g].mode == MODE_CONSTANT);
    assign addressed = ACTIVE && enabled && (stage_motor == 1'(g));
    assign ramping   = (st[g].ramp_mode == RAMP_ACCEL) || (st[g].ramp_mode == RAMP_DECEL);

    always_comb begin
      st_next[g] = st[g];
      unique case (stage_command)
        CMD_TICK: begin
          if (ACTIVE) begin
            st_next[g].pulse_elapsed = pe;
            st_next[g].ramp_elapsed  = re;
            if (cfg[g].mode == MODE_STEP) begin
              // Step-count mode: toggle past the step delay, count falling edges.
              if ((st[g].remaining_steps != '0) &&
                  (pe > ELAPSED_WIDTH'(cfg[g].step_delay))) begin
                st_next[g].pulse_elapsed = '0;
                st_next[g].step_level    = !st[g].step_level;
                if (st[g].step_level) begin
                  st_next[g].remaining_steps = st[g].remaining_steps - 1'b1;
                end
              end
            end else if ((cfg[g].mode == MODE_CONSTANT) && ramping) begin
              // Constant mode: toggle past the current delay, ramp on falling edges.
              if (pe > ELAPSED_WIDTH'(st[g].ramp_delay)) begin
                st_next[g].pulse_elapsed = '0;
                st_next[g].step_level    = !st[g].step_level;
                if (st[g].step_level &&
                    (re > ELAPSED_WIDTH'(cfg[g].ramp_interval))) begin
                  if ((st[g].ramp_mode == RAMP_ACCEL) &&
                      (st[g].ramp_delay > cfg[g].step_delay)) begin
                    st_next[g].ramp_delay   = st[g].ramp_delay - 1'b1;
                    st_next[g].ramp_elapsed = '0;
                  end else if ((st[g].ramp_mode == RAMP_DECEL) &&
                               (st[g].ramp_delay < cfg[g].start_delay)) begin
                    st_next[g].ramp_delay   = st[g].ramp_delay + 1'b1;
                    st_next[g].ramp_elapsed = '0;
                  end
                end
              end
            end
          end
        end
        CMD_SET_STEPS: begin
          if (addressed) begin
            st_next[g].remaining_steps = stage_value;
          end
        end
        CMD_SET_RAMP: begin
          // Ramp states above decelerate are ignored.
          if (addressed && (stage_value <= DELAY_W'(RAMP_DECEL))) begin
            st_next[g].ramp_mode = stage_value[1:0];
            if (stage_value[1:0] == RAMP_ACCEL) begin
              st_next[g].ramp_delay = cfg[g].start_delay;
            end
          end
        end
        CMD_SET_DIR: begin
          if (addressed) begin
            st_next[g].dir_level = (stage_value != '0);
          end
        end
        default: ;
      endcase
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[g] <= '0;
      end else if (advance) begin
        st[g] <= st_next[g];
      end
    end
  end

  // Result word straight from the motor state registers.
  assign result.valid        = res_valid;
  assign result.step_out_0   = st[0].step_level;
  assign result.step_out_1   = st[1].step_level;
  assign result.dir_out_0    = st[0].dir_level;
  assign result.dir_out_1    = st[1].dir_level;
  assign result.steps_left_0 = st[0].remaining_steps;
  assign result.steps_left_1 = st[1].remaining_steps;
  assign result.cur_delay_0  = st[0].ramp_delay;
  assign result.cur_delay_1  = st[1].ramp_delay;
  assign result.ramp_state_0 = st[0].ramp_mode;
  assign result.ramp_state_1 = st[1].ramp_mode;

endmodule

[sim/dual_stepper_pulse_ramp_generator_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual stepper step-pulse and ramp generator testbench
// Drives tick and set-up command words with random gaps, stalls the status
// channel at random, and compares every status word with a cycle-free model
// of both motors kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module dual_stepper_pulse_ramp_generator_core_tb;
  import dspr_pkg::*;

  // The unused mode code is also treated as disabled by the block.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int         HOLD_CYCLES = 150;
  localparam int         NUM_PHASES  = 8;

  // One status word as it leaves the block.
  typedef struct packed {
    logic        step_out_0;
    logic        step_out_1;
    logic        dir_out_0;
    logic        dir_out_1;
    logic [15:0] steps_left_0;
    logic [15:0] steps_left_1;
    logic [15:0] cur_delay_0;
    logic [15:0] cur_delay_1;
    logic [1:0]  ramp_state_0;
    logic [1:0]  ramp_state_1;
  } status_t;

  // Tracks both motors and the status words that are still owed.
  class step_ramp_tracker;
    bit [1:0]               mode [2];
    bit [15:0]              step_delay [2];
    bit [15:0]              start_delay [2];
    bit [15:0]              interval [2];
    bit                     step_level [2];
    bit                     dir_level [2];
    bit [15:0]              steps_left [2];
    bit [1:0]               ramp [2];
    bit [15:0]              delay [2];
    bit [ELAPSED_WIDTH-1:0] pulse_ticks [2];
    bit [ELAPSED_WIDTH-1:0] ramp_ticks [2];
    status_t                status_due [$];
    int errors, words, ticks, edges, ramp_moves, ignored;

    function new();
      mode[0] = MODE_DISABLED;
      mode[1] = MODE_DISABLED;
    endfunction

    function void set_register(logic [2:0] idx, bit [15:0] data);
      case (idx)
        REG_M0_MODE:     mode[0] = data[1:0];
        REG_M1_MODE:     mode[1] = data[1:0];
        REG_M0_STEP_DLY: step_delay[0] = data;
        REG_M1_STEP_DLY: step_delay[1] = data;
        REG_M0_START:    start_delay[0] = data;
        REG_M1_START:    start_delay[1] = data;
        REG_M0_INTERVAL: interval[0] = data;
        default:         interval[1] = data;
      endcase
    endfunction

    // Set-up commands to a disabled motor and unknown ramp codes change nothing.
    function bit ignores(cmd_t cmd, bit mtr, bit [15:0] val);
      return cmd != CMD_TICK &&
             (mode[mtr] > MODE_CONSTANT || (cmd == CMD_SET_RAMP && val > RAMP_DECEL));
    endfunction

    function bit [ELAPSED_WIDTH-1:0] bump(bit [ELAPSED_WIDTH-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // Toggles the step line and reports a falling edge.
    function bit flip(int m);
      pulse_ticks[m] = '0;
      step_level[m] = !step_level[m];
      if (!step_level[m])
        edges++;
      return !step_level[m];
    endfunction

    function void step_motor(int m);
      bit falling;
      pulse_ticks[m] = bump(pulse_ticks[m]);
      ramp_ticks[m] = bump(ramp_ticks[m]);
      if (mode[m] == MODE_STEP) begin
        if (steps_left[m] != 0 && pulse_ticks[m] > step_delay[m]) begin
          falling = flip(m);
          if (falling)
            steps_left[m]--;
        end
      end else if (mode[m] == MODE_CONSTANT && (ramp[m] == RAMP_ACCEL || ramp[m] == RAMP_DECEL)) begin
        if (pulse_ticks[m] > delay[m]) begin
          falling = flip(m);
          // The ramp only moves on a falling edge once its interval has run out.
          if (falling && ramp_ticks[m] > interval[m]) begin
            if (ramp[m] == RAMP_ACCEL && delay[m] > step_delay[m]) begin
              delay[m]--;
              ramp_ticks[m] = '0;
              ramp_moves++;
            end else if (ramp[m] == RAMP_DECEL && delay[m] < start_delay[m]) begin
              delay[m]++;
              ramp_ticks[m] = '0;
              ramp_moves++;
            end
          end
        end
      end
    endfunction

    function void note_word(cmd_t cmd, bit mtr, bit [15:0] val);
      status_t s;
      if (cmd == CMD_TICK) begin
        ticks++;
        for (int m = 0; m < NUM_MOTORS; m++)
          step_motor(m);
      end else if (ignores(cmd, mtr, val)) begin
        ignored++;
      end else begin
        case (cmd)
          CMD_SET_STEPS: steps_left[mtr] = val;
          CMD_SET_RAMP: begin
            ramp[mtr] = val[1:0];
            if (val[1:0] == RAMP_ACCEL)
              delay[mtr] = start_delay[mtr];
          end
          default: dir_level[mtr] = (val != 0);
        endcase
      end
      s.step_out_0   = step_level[0];
      s.step_out_1   = step_level[1];
      s.dir_out_0    = dir_level[0];
      s.dir_out_1    = dir_level[1];
      s.steps_left_0 = steps_left[0];
      s.steps_left_1 = steps_left[1];
      s.cur_delay_0  = delay[0];
      s.cur_delay_1  = delay[1];
      s.ramp_state_0 = ramp[0];
      s.ramp_state_1 = ramp[1];
      status_due.push_back(s);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (status_due.size() == 0) begin
        $error("status word arrived with no command outstanding");
        errors++;
        return;
      end
      want = status_due.pop_front();
      words++;
      compare("step_out_0", 16'(want.step_out_0), 16'(got.step_out_0));
      compare("step_out_1", 16'(want.step_out_1), 16'(got.step_out_1));
      compare("dir_out_0", 16'(want.dir_out_0), 16'(got.dir_out_0));
      compare("dir_out_1", 16'(want.dir_out_1), 16'(got.dir_out_1));
      compare("steps_left_0", want.steps_left_0, got.steps_left_0);
      compare("steps_left_1", want.steps_left_1, got.steps_left_1);
      compare("cur_delay_0", want.cur_delay_0, got.cur_delay_0);
      compare("cur_delay_1", want.cur_delay_1, got.cur_delay_1);
      compare("ramp_state_0", 16'(want.ramp_state_0), 16'(got.ramp_state_0));
      compare("ramp_state_1", 16'(want.ramp_state_1), 16'(got.ramp_state_1));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  dspr_cmd_if word_in ();
  dspr_res_if status_out ();

  step_ramp_tracker tracker = new();

  bit no_gaps;
  bit hold_result;
  int holds_done;

  dual_stepper_pulse_ramp_generator_core dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (word_in),
    .result  (status_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels and keep the scoreboard in step with the block.
  always @(posedge clk) begin
    if (!rst && word_in.valid && word_in.ready)
      tracker.note_word(word_in.command, word_in.motor, word_in.value);
  end

  always @(posedge clk) begin
    if (!rst && status_out.valid && status_out.ready)
      tracker.check_status('{step_out_0: status_out.step_out_0,
                             step_out_1: status_out.step_out_1,
                             dir_out_0: status_out.dir_out_0,
                             dir_out_1: status_out.dir_out_1,
                             steps_left_0: status_out.steps_left_0,
                             steps_left_1: status_out.steps_left_1,
                             cur_delay_0: status_out.cur_delay_0,
                             cur_delay_1: status_out.cur_delay_1,
                             ramp_state_0: status_out.ramp_state_0,
                             ramp_state_1: status_out.ramp_state_1});
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (no_gaps)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Status consumer: random stalls, steady stretches, and a long hold on request.
  initial begin : status_sink
    int span;
    status_out.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_result) begin
        status_out.ready <= 1'b0;
        span = HOLD_CYCLES;
        hold_result = 1'b0;
        holds_done++;
      end else if (no_gaps) begin
        status_out.ready <= 1'b1;
        span = 1;
      end else begin
        status_out.ready <= ($urandom_range(0, 3) != 0);
        span = 1 + pick_gap();
      end
      repeat (span) @(posedge clk);
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("dual_stepper_pulse_ramp_generator_core: mismatch");
    $finish;
  end

  // Offer one command word and wait until the block takes it.
  task automatic send_word(input cmd_t cmd, input bit mtr, input logic [15:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      word_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_in.valid   <= 1'b1;
    word_in.command <= cmd;
    word_in.motor   <= mtr;
    word_in.value   <= val;
    do @(posedge clk); while (!word_in.ready);
  endtask

  // Setup then access phase; psel stays up across back-to-back writes.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= DATA_W'(data);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_register(idx, data);
  endtask

  task automatic apb_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_motor(input int m, input logic [1:0] md, input int sd, st, iv);
    write_reg(3'(REG_M0_MODE + m), 16'(md));
    write_reg(3'(REG_M0_STEP_DLY + m), 16'(sd));
    write_reg(3'(REG_M0_START + m), 16'(st));
    write_reg(3'(REG_M0_INTERVAL + m), 16'(iv));
  endtask

  // Drop valid and wait for every owed status word before touching registers.
  // The first edge lets the monitor note a word taken at the previous edge.
  task automatic settle();
    word_in.valid <= 1'b0;
    @(posedge clk);
    while (tracker.status_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Phase one holds the extremes; phase two parks both motors.
  task automatic configure_phase(input int k);
    bit [1:0] md;
    int       sd, st, iv, roll;
    for (int m = 0; m < NUM_MOTORS; m++) begin
      roll = $urandom_range(0, 99);
      if (k == 1)
        md = m ? MODE_CONSTANT : MODE_STEP;
      else if (k == 2)
        md = m ? MODE_SPARE : MODE_DISABLED;
      else if (roll < 45)
        md = MODE_STEP;
      else if (roll < 92)
        md = MODE_CONSTANT;
      else if (roll < 96)
        md = MODE_DISABLED;
      else
        md = MODE_SPARE;
      sd = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(0, 16'hFFFF);
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        st = sd + $urandom_range(0, 10);
        if (st > 16'hFFFF)
          st = 16'hFFFF;
      end else if (roll < 90) begin
        st = $urandom_range(0, 4);
      end else begin
        st = 16'hFFFF;
      end
      iv = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(0, 16'hFFFF);
      if (k == 1) begin
        sd = m ? 16'hFFFF : 0;
        st = m ? 0 : 16'hFFFF;
        iv = m ? 0 : 16'hFFFF;
      end
      set_motor(m, md, sd, st, iv);
    end
    apb_idle();
  endtask

  // Hold the status channel while the command side keeps offering words.
  task automatic stall_results();
    bit keep;
    keep = no_gaps;
    hold_result = 1'b1;
    no_gaps = 1'b1;
    repeat (60) send_word(CMD_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
    no_gaps = keep;
  endtask

  // Mostly tick bursts and sensible set-up commands, with some raw noise.
  task automatic run_phase(input int target, input bit with_hold);
    int          counted, roll, burst;
    cmd_t        cmd;
    bit          mtr;
    logic [15:0] val;
    counted = 0;
    if (with_hold) begin
      stall_results();
      counted = 60;
    end
    while (counted < target) begin
      roll = $urandom_range(0, 99);
      mtr = 1'($urandom_range(0, 1));
      val = 16'($urandom_range(0, 16'hFFFF));
      if (roll < 60) begin
        burst = $urandom_range(1, 12);
        repeat (burst) send_word(CMD_TICK, 1'($urandom_range(0, 1)), 16'($urandom));
        counted += burst;
      end else begin
        if (roll < 92) begin
          cmd = cmd_t'($urandom_range(CMD_SET_STEPS, CMD_SET_DIR));
          case (cmd)
            CMD_SET_STEPS: if ($urandom_range(0, 9) < 9) val = 16'($urandom_range(0, 24));
            CMD_SET_RAMP:  val = 16'($urandom_range(RAMP_STOP, RAMP_DECEL));
            default:       if ($urandom_range(0, 1) == 0) val = '0;
          endcase
        end else begin
          cmd = cmd_t'($urandom_range(0, 3));
        end
        if (!tracker.ignores(cmd, mtr, val))
          counted++;
        send_word(cmd, mtr, val);
      end
    end
  endtask

  initial begin : stimulus
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    word_in.valid   = 1'b0;
    word_in.command = CMD_TICK;
    word_in.motor   = 1'b0;
    word_in.value   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Both motors come out of reset disabled and ignore set-up commands.
    send_word(CMD_SET_STEPS, 1'b0, 16'd5);
    send_word(CMD_SET_DIR, 1'b1, 16'd1);
    send_word(CMD_TICK, 1'b0, 16'd0);
    settle();

    // Directed pass: step count on motor 0, ramp on motor 1.
    set_motor(0, MODE_STEP, 1, 4, 0);
    set_motor(1, MODE_CONSTANT, 1, 4, 1);
    apb_idle();
    send_word(CMD_SET_DIR, 1'b0, 16'hFFFF);
    send_word(CMD_SET_DIR, 1'b1, 16'd1);
    send_word(CMD_SET_DIR, 1'b1, 16'd0);
    send_word(CMD_SET_STEPS, 1'b0, 16'hFFFF);
    send_word(CMD_SET_STEPS, 1'b0, 16'd2);
    repeat (4) send_word(CMD_TICK, 1'b0, 16'd0);
    send_word(CMD_SET_RAMP, 1'b1, 16'(RAMP_ACCEL));
    repeat (5) send_word(CMD_TICK, 1'b1, 16'hFFFF);
    // Unknown ramp codes leave the ramp state alone.
    send_word(CMD_SET_RAMP, 1'b1, 16'd3);
    send_word(CMD_SET_RAMP, 1'b1, 16'hFFFF);
    send_word(CMD_SET_RAMP, 1'b1, 16'(RAMP_DECEL));
    repeat (3) send_word(CMD_TICK, 1'b0, 16'd0);
    send_word(CMD_SET_RAMP, 1'b1, 16'(RAMP_STOP));
    send_word(CMD_SET_STEPS, 1'b0, 16'd0);
    // Ramp commands are taken in step mode as well.
    send_word(CMD_SET_RAMP, 1'b0, 16'(RAMP_ACCEL));
    send_word(CMD_TICK, 1'b0, 16'd0);
    settle();

    // Random phases, each under its own register setting.
    for (int k = 1; k <= NUM_PHASES; k++) begin
      configure_phase(k);
      no_gaps = (k == 3 || k == 6);
      run_phase((k == 2) ? 40 : 115, (k == 4 || k == 7));
      settle();
    end
    repeat (8) @(posedge clk);

    if (tracker.status_due.size() != 0) begin
      $error("%0d status words never arrived", tracker.status_due.size());
      tracker.errors++;
    end
    $display("Checked %0d status words over %0d register settings, %0d of them ticks.",
             tracker.words, NUM_PHASES + 1, tracker.ticks);
    $display("Saw %0d falling step edges, %0d ramp delay moves, %0d ignored commands, %0d holds.",
             tracker.edges, tracker.ramp_moves, tracker.ignored, holds_done);
    if (tracker.errors == 0)
      $display("dual_stepper_pulse_ramp_generator_core: match");
    else
      $display("dual_stepper_pulse_ramp_generator_core: mismatch");
    $finish;
  end

endmodule
